### rtl/dqp_pkg.sv
// shared types and constants for the dns question parser
`default_nettype none

package dqp_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int NAME_BUFFER = 256;
    localparam logic [7:0] LABEL_TYPE_MASK = 8'hC0;
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [15:0] CLASS_RESET = 16'd1;

    typedef enum logic [2:0]
    {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_LABEL  = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [2:0]
    {
        V_OK         = 3'd0,
        V_TRUNC      = 3'd1,
        V_LABEL_TYPE = 3'd2,
        V_TOO_LONG   = 3'd3,
        V_EMPTY      = 3'd4,
        V_CLASS      = 3'd5
    } verdict_t;

    typedef struct packed
    {
        logic        is_verdict;
        logic [7:0]  name_char;
        verdict_t    verdict_code;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [7:0]  name_length;
    } result_t;

endpackage

`default_nettype wire

### rtl/dqp_parse.sv
// per-byte parse state and result decision
`default_nettype none

module dqp_parse
    import dqp_pkg::*;
#(
    parameter int NAME_BUFFER = dqp_pkg::NAME_BUFFER
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             res_valid,
    output result_t          res
);

    logic [15:0] required_class_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [5:0]  label_remaining_reg, label_remaining_next;
    logic [7:0]  name_count_reg, name_count_next;
    logic [1:0]  tail_index_reg, tail_index_next;
    logic [23:0] tail_bytes_reg, tail_bytes_next;

    logic [8:0]  used;
    logic [9:0]  needed;
    logic [15:0] qc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            required_class_reg <= CLASS_RESET;
        else if (cfg_we)
            required_class_reg <= cfg_data;
    end

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        header_count_next = header_count_reg;
        label_remaining_next = label_remaining_reg;
        name_count_next = name_count_reg;
        tail_index_next = tail_index_reg;
        tail_bytes_next = tail_bytes_reg;
        res_valid = 1'b0;
        res = '0;
        used = (name_count_reg != 8'd0) ? ({1'b0, name_count_reg} + 9'd1) : 9'd0;
        needed = {1'b0, used} + {4'b0, data_byte[5:0]} + 10'd1;
        qc = {tail_bytes_reg[7:0], data_byte};

        case (phase_reg)
            PH_HEADER:
            begin
                header_count_next = header_count_reg + 4'd1;
                if (header_count_next >= 4'(HEADER_BYTES))
                    phase_next = PH_LENGTH;
                if (last_byte)
                begin
                    res_valid = 1'b1;
                    res.verdict_code = V_TRUNC;
                end
            end
            PH_LENGTH:
            begin
                if (data_byte == 8'd0)
                begin
                    if (name_count_reg == 8'd0)
                    begin
                        res_valid = 1'b1;
                        res.verdict_code = V_EMPTY;
                    end
                    else if (last_byte)
                    begin
                        res_valid = 1'b1;
                        res.verdict_code = V_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                        tail_index_next = 2'd0;
                        tail_bytes_next = 24'd0;
                    end
                end
                else if ((data_byte & LABEL_TYPE_MASK) != 8'd0)
                begin
                    res_valid = 1'b1;
                    res.verdict_code = V_LABEL_TYPE;
                end
                else if (last_byte)
                begin
                    res_valid = 1'b1;
                    res.verdict_code = V_TRUNC;
                end
                else if (needed >= 10'(NAME_BUFFER))
                begin
                    res_valid = 1'b1;
                    res.verdict_code = V_TOO_LONG;
                end
                else
                begin
                    label_remaining_next = data_byte[5:0];
                    phase_next = PH_LABEL;
                    if (name_count_reg != 8'd0)
                    begin
                        // separator ahead of every label but the first
                        name_count_next = name_count_reg + 8'd1;
                        res_valid = 1'b1;
                        res.name_char = DOT_CHAR;
                    end
                end
            end
            PH_LABEL:
            begin
                if (last_byte)
                begin
                    res_valid = 1'b1;
                    res.verdict_code = V_TRUNC;
                end
                else
                begin
                    name_count_next = name_count_reg + 8'd1;
                    label_remaining_next = label_remaining_reg - 6'd1;
                    if (label_remaining_next == 6'd0)
                        phase_next = PH_LENGTH;
                    res_valid = 1'b1;
                    res.name_char = data_byte;
                end
            end
            PH_TAIL:
            begin
                if (tail_index_reg == 2'd3)
                begin
                    res_valid = 1'b1;
                    res.verdict_code = (qc == required_class_reg) ? V_OK : V_CLASS;
                    res.query_type = tail_bytes_reg[23:8];
                    res.query_class = qc;
                end
                else
                begin
                    tail_bytes_next = {tail_bytes_reg[15:0], data_byte};
                    tail_index_next = tail_index_reg + 2'd1;
                    if (last_byte)
                    begin
                        res_valid = 1'b1;
                        res.verdict_code = V_TRUNC;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (res_valid)
        begin
            res.is_verdict = (phase_reg == PH_HEADER) || (phase_reg == PH_TAIL)
                || (res.name_char == 8'd0 && !(phase_reg == PH_LABEL && !last_byte)
                    && !(phase_reg == PH_LENGTH && res.verdict_code == V_OK
                         && phase_next == PH_LABEL));
            res.name_length = name_count_next;
            if (res.is_verdict)
                phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            header_count_reg <= 4'd0;
            label_remaining_reg <= 6'd0;
            name_count_reg <= 8'd0;
            tail_index_reg <= 2'd0;
            tail_bytes_reg <= 24'd0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg <= PH_HEADER;
                header_count_reg <= 4'd0;
                label_remaining_reg <= 6'd0;
                name_count_reg <= 8'd0;
                tail_index_reg <= 2'd0;
                tail_bytes_reg <= 24'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                header_count_reg <= header_count_next;
                label_remaining_reg <= label_remaining_next;
                name_count_reg <= name_count_next;
                tail_index_reg <= tail_index_next;
                tail_bytes_reg <= tail_bytes_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/dqp_out_buf.sv
// result register with one skid entry
`default_nettype none

module dqp_out_buf
    import dqp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         can_take,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop = main_valid_reg && out_ready;
    assign can_take = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/dns_question_parser_unit.sv
// top level of the dns question parser
// output: result words are registered, via the skid entry when the master side stalls
// throughput: one message byte per cycle while the skid entry is empty; the skid entry
//   keeps the input open for one more word while a result waits on the master side
// reset: rst_n asynchronous active low; parse state returns to the header phase and
//   required_class to 1; the parse state also clears after every last byte
`default_nettype none

module dns_question_parser_unit
    import dqp_pkg::*;
#(
    parameter int NAME_BUFFER = dqp_pkg::NAME_BUFFER   // name buffer size, 16 to 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: required_class
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // last_byte
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // name_char, verdict_code, query_type,
                                        // query_class, name_length, zero fill
    output logic             m_tuser    // is_verdict
);

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    can_take;
    result_t out_res;

    // register writes land whenever offered
    assign cfg_ready = 1'b1;

    assign s_tready = can_take;
    assign accept = s_tvalid && s_tready;

    // byte walker: header skip, label walk, type and class collection
    dqp_parse
    #(
        .NAME_BUFFER (NAME_BUFFER)
    )
    u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register plus skid entry toward the master side
    dqp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack fields from the lowest bit up
    assign m_tdata = {5'd0, out_res.name_length, out_res.query_class, out_res.query_type,
                      out_res.verdict_code, out_res.name_char};
    assign m_tuser = out_res.is_verdict;

endmodule

`default_nettype wire
